// ===== hdl/mp22_pkg.sv =====
package mp22_pkg;

  // Width of the configuration registers and of the write data port
  localparam int CFG_W = 9;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } cfg_reg_t;

  // Reset value of both map dimensions
  localparam logic [CFG_W-1:0] MAP_DIM_RESET = CFG_W'(256);

endpackage

// ===== hdl/mp22_line_ram.sv =====
module mp22_line_ram #(
  parameter int DATA_WIDTH = 16,
  parameter int DEPTH      = 128,
  parameter int AW         = 7
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds its data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/max_pool_2x2_stride2.sv =====
// Pipeline: the pixel that closes a window starts the line store read, which stage 1
//   waits for; the pooled item then moves into the output register.
// Throughput: one pixel per cycle, limited by the single read and write port of the
//   line store; the input stalls only while stage 1 and the output register both hold
//   an item and the output is stalled.
// Reset: synchronous, clears counters, pipeline valids and map size (256 x 256);
//   the line store is not cleared, every entry is written on an even row before use.
module max_pool_2x2_stride2 import mp22_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_write,
  input  logic [0:0]                   cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  // pixel input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] pixel_value,
  // pooled output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] pooled_value,
  output logic                         last_in_map
);

  localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CCW        = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW         = ($clog2(MAX_WIDTH) + 1 > CFG_W) ?
                              $clog2(MAX_WIDTH) + 1 : CFG_W;
  localparam int RW         = CFG_W + 1;

  logic [CFG_W-1:0] map_width;
  logic [CFG_W-1:0] map_height;

  logic [CCW-1:0]   col;
  logic [CCW-1:0]   col_next;
  logic [CFG_W-1:0] row;
  logic [CFG_W-1:0] row_next;

  logic signed [DATA_WIDTH-1:0] first_of_pair;

  logic [WW-1:0] width_eff;
  logic [WW-1:0] width_even;
  logic [WW-1:0] col_ext;
  logic [WW-1:0] col_inc;
  logic [RW-1:0] height_eff;
  logic [RW-1:0] height_even;
  logic [RW-1:0] row_ext;
  logic [RW-1:0] row_inc;

  logic                         accept;
  logic                         in_window;
  logic                         line_wr;
  logic                         line_rd;
  logic                         window_last;
  logic [AW-1:0]                slot;
  logic signed [DATA_WIDTH-1:0] pair_max;
  logic [DATA_WIDTH-1:0]        line_rd_data;

  logic                         s1_valid;
  logic                         s1_last;
  logic signed [DATA_WIDTH-1:0] s1_pair_max;
  logic                         s1_advance;
  logic signed [DATA_WIDTH-1:0] s1_result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= MAP_DIM_RESET;
      map_height <= MAP_DIM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAP_WIDTH:  map_width  <= cfg_data;
        REG_MAP_HEIGHT: map_height <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Clamp the map size and round down to whole windows
  always_comb begin
    width_eff = WW'(map_width);
    if (width_eff < WW'(2)) begin
      width_eff = WW'(2);
    end else if (width_eff > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end
    width_even = {width_eff[WW-1:1], 1'b0};

    height_eff = RW'(map_height);
    if (height_eff < RW'(2)) begin
      height_eff = RW'(2);
    end
    height_even = {height_eff[RW-1:1], 1'b0};
  end

  // Pipeline flow: stage 1 moves on unless the output register is held
  assign s1_advance = !out_valid || !out_stall;
  assign in_stall   = s1_valid && !s1_advance;
  assign accept     = in_valid && !in_stall;

  // Window position and pair maximum for the current pixel
  assign col_ext     = WW'(col);
  assign row_ext     = RW'(row);
  assign in_window   = col[0] && (col_ext < width_even) && (row_ext < height_even);
  assign line_wr     = accept && in_window && !row[0];
  assign line_rd     = accept && in_window && row[0];
  assign window_last = (col_ext == width_even - WW'(1)) &&
                       (row_ext == height_even - RW'(1));
  assign slot        = AW'(col_ext >> 1);
  assign pair_max    = (first_of_pair < pixel_value) ? pixel_value : first_of_pair;

  // Raster counters
  always_comb begin
    col_inc  = col_ext + WW'(1);
    row_inc  = row_ext + RW'(1);
    col_next = CCW'(col_inc);
    row_next = row;
    if (col_inc >= width_eff) begin
      col_next = '0;
      row_next = (row_inc >= height_eff) ? '0 : CFG_W'(row_inc);
    end else if (row_ext >= height_eff) begin
      row_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col           <= '0;
      row           <= '0;
      first_of_pair <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
      if (!col[0]) begin
        first_of_pair <= pixel_value;
      end
    end
  end

  // Line store of pair maxima from the even row
  mp22_line_ram #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (LINE_DEPTH),
    .AW         (AW)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_addr (slot),
    .wr_data (pair_max),
    .rd_en   (line_rd),
    .rd_addr (slot),
    .rd_data (line_rd_data)
  );

  // Stage 1: wait for the line store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || s1_advance) begin
      s1_valid <= line_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (line_rd) begin
      s1_pair_max <= pair_max;
      s1_last     <= window_last;
    end
  end

  assign s1_result = ($signed(line_rd_data) < s1_pair_max) ? s1_pair_max
                                                           : $signed(line_rd_data);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      pooled_value <= s1_result;
      last_in_map  <= s1_last;
    end
  end

endmodule

// ===== dv/tb_max_pool_2x2_stride2.sv =====
module tb_max_pool_2x2_stride2;
  import mp22_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH    = 256;
  localparam int DATA_WIDTH   = 16;
  localparam int LINE_DEPTH   = MAX_WIDTH / 2;
  localparam int HOLD_CYCLES  = 300;
  localparam int WATCHDOG_MAX = 2000;
  localparam int SETTLE       = 4;

  typedef logic signed [DATA_WIDTH-1:0] pixel_t;

  typedef struct {
    pixel_t value;
    logic   last;
  } pooled_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [0:0]           cfg_index = REG_MAP_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  pixel_t               pixel_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  pixel_t               pooled_value;
  logic                 last_in_map;

  // pixels waiting to be offered, pooled items still owed by the block
  pixel_t               pixel_queue[$];
  pooled_item_t         expected_pooled[$];

  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   hold_requests = 0;
  int                   holds_served;
  int                   hold_left;
  int                   idle_cycles;
  int                   fail_count = 0;

  // mirror of the pooling state
  logic [CFG_W-1:0]     map_width_q;
  logic [CFG_W-1:0]     map_height_q;
  pixel_t               pair_line[LINE_DEPTH];
  pixel_t               first_px;
  int unsigned          col_cnt;
  int unsigned          row_cnt;

  max_pool_2x2_stride2 #(
    .MAX_WIDTH  (MAX_WIDTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_value  (pixel_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pooled_value (pooled_value),
    .last_in_map  (last_in_map)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic pixel_t pair_larger(input pixel_t a, input pixel_t b);
    return (a < b) ? b : a;
  endfunction

  // Advance the window counters by one pixel and queue the pooled item it closes
  function automatic void pool_window_step(input pixel_t px);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    int unsigned  r;
    int unsigned  slot;
    pixel_t       pm;
    pooled_item_t item;
    w = int'(map_width_q);
    h = int'(map_height_q);
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 2) h = 2;
    c = col_cnt;
    r = row_cnt;
    if (c[0] == 1'b0) begin
      first_px = px;
    end else if (c < 2 * (w / 2) && r < 2 * (h / 2)) begin
      slot = (c >> 1) % LINE_DEPTH;
      pm = pair_larger(first_px, px);
      if (r[0] == 1'b0) begin
        pair_line[slot] = pm;
      end else begin
        item.value = pair_larger(pair_line[slot], pm);
        item.last = (c == 2 * (w / 2) - 1) && (r == 2 * (h / 2) - 1);
        expected_pooled.push_back(item);
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end else if (r >= h) begin
      r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endfunction

  // Check the output side first so a pixel accepted now can never match at once
  always @(posedge clk) begin
    pooled_item_t want;
    if (rst) begin
      map_width_q  = MAP_DIM_RESET;
      map_height_q = MAP_DIM_RESET;
      first_px     = '0;
      col_cnt      = 0;
      row_cnt      = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pooled.size() == 0) begin
          report_mismatch($sformatf("unexpected pooled item %0d last %0b",
                                    pooled_value, last_in_map));
        end else begin
          want = expected_pooled.pop_front();
          if (pooled_value !== want.value)
            report_mismatch($sformatf("pooled_value %0d, want %0d",
                                      pooled_value, want.value));
          if (last_in_map !== want.last)
            report_mismatch($sformatf("last_in_map %0b, want %0b (value %0d)",
                                      last_in_map, want.last, want.value));
        end
      end
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAP_WIDTH:  map_width_q = cfg_data;
          REG_MAP_HEIGHT: map_height_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        pool_window_step(pixel_value);
    end
  end

  // Offer the next pixel once the current item has gone, idling at random
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid    <= 1'b1;
        pixel_value <= pixel_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the output at random, or hold it off for a long stretch on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall    <= 1'b0;
      hold_left    <= 0;
      holds_served <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 29; recv_idle_pct = 51; end
      1: begin send_idle_pct = 51; recv_idle_pct = 29; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(REG_MAP_WIDTH, w);
    write_reg(REG_MAP_HEIGHT, h);
  endtask

  // Wait until every pixel is taken and every pooled item is back, then settle
  task automatic wait_drained(input int settle);
    @(negedge clk);
    while (pixel_queue.size() != 0 || in_valid || expected_pooled.size() != 0)
      @(negedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return pixel_t'($urandom_range(8) - 4);
      default: return pixel_t'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic push_pixel(input pixel_t px);
    @(negedge clk);
    pixel_queue.push_back(px);
  endtask

  task automatic push_random(input int count);
    @(negedge clk);
    repeat (count) pixel_queue.push_back(rand_pixel());
  endtask

  // Mostly small maps, now and then degenerate or oversized dimensions
  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(9))
      0:       return CFG_W'($urandom_range(1));
      1:       return CFG_W'($urandom_range(40, 13));
      2:       return CFG_W'($urandom_range(511, 257));
      default: return CFG_W'($urandom_range(12, 2));
    endcase
  endfunction

  task automatic random_phase();
    write_dims(pick_dim(), pick_dim());
    push_random($urandom_range(60, 30));
    wait_drained(SETTLE);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_idling(0);

    // smallest map: field extremes, then a window of equal minimum values
    write_dims(9'd2, 9'd2);
    push_pixel(16'sh7FFF); push_pixel(16'sh8000); push_pixel(-16'sd1); push_pixel(16'sd0);
    push_pixel(16'sh8000); push_pixel(16'sh8000); push_pixel(16'sh8000); push_pixel(16'sh8000);
    wait_drained(SETTLE);

    // dimensions below the minimum act as two
    write_dims(9'd0, 9'd1);
    push_pixel(-16'sd2); push_pixel(-16'sd1); push_pixel(-16'sd32767); push_pixel(-16'sd3);
    wait_drained(SETTLE);

    // odd width and height: trailing column and row are dropped
    write_dims(9'd3, 9'd3);
    push_pixel(16'sd5);   push_pixel(16'sd7);   push_pixel(16'sd100);
    push_pixel(-16'sd4);  push_pixel(16'sd6);   push_pixel(16'sd200);
    push_pixel(16'sd300); push_pixel(16'sd300); push_pixel(16'sd300);
    wait_drained(SETTLE);

    // full-width first row fills the whole line store
    write_dims(9'd256, 9'd2);
    push_random(256);
    wait_drained(SETTLE);
    // oversized width in mid-map must clamp to the line store
    write_reg(REG_MAP_WIDTH, 9'd511);
    push_random(256);
    wait_drained(SETTLE);

    repeat (3) random_phase();

    // tall narrow map with a long output hold-off, then grow the height mid-map
    set_idling(1);
    write_dims(9'd2, 9'd256);
    push_random(500);
    hold_requests++;
    wait_drained(SETTLE);
    write_reg(REG_MAP_HEIGHT, 9'd258);
    push_random(20);
    wait_drained(SETTLE);

    repeat (3) random_phase();
    set_idling(2);
    repeat (3) random_phase();

    wait_drained(10);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
